// File: sv/urfc_pkg.sv
// Shared types and constants for the response frame checker.
`timescale 1ns / 1ps

package urfc_pkg;

  // Input item codes
  localparam logic [1:0] FN_START = 2'd0;
  localparam logic [1:0] FN_BYTE  = 2'd1;
  localparam logic [1:0] FN_TICK  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_BAD_CHECK = 3'd3;
  localparam logic [2:0] ST_WRONG_CMD = 3'd4;
  localparam logic [2:0] ST_SHORT     = 3'd5;
  localparam logic [2:0] ST_UNKNOWN   = 3'd6;

  // Frame constants
  localparam logic [7:0] START_BYTE       = 8'hFE;
  localparam logic [7:0] VER_CMD0         = 8'h61;
  localparam logic [7:0] VER_CMD1         = 8'h02;
  localparam logic [7:0] INFO_CMD0        = 8'h67;
  localparam logic [7:0] INFO_CMD1        = 8'h00;
  localparam logic [7:0] VER_MIN_PAYLOAD  = 8'd9;
  localparam logic [7:0] INFO_MIN_PAYLOAD = 8'd12;
  localparam int         FIELD_N          = 12;
  localparam int         FIELD_IDX_W      = 4;
  localparam int         HDR_BYTES        = 4;
  localparam int         LEN_W            = 9;
  localparam int         TICK_W           = 10;
  localparam int         EVT_BYTES        = 10;
  localparam int         EVT_INFO_TYPE    = 9;
  localparam logic [7:0] MAX_ROLE         = 8'd2;
  localparam logic [7:0] MAX_FAMILY       = 8'd2;
  localparam logic [1:0] FAMILY_UNKNOWN   = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic       probe_kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        kind_done;
    logic [7:0]  transport_rev;
    logic [7:0]  product;
    logic [1:0]  chip_family;
    logic [7:0]  major_rel;
    logic [7:0]  minor_rel;
    logic [7:0]  maint_rel;
    logic [31:0] revision;
    logic [1:0]  role;
    logic [7:0]  device_status;
  } out_t;

  // Classified frame end, handed from front to back.
  // data[0..8] are payload bytes 0..8, data[9] is payload byte 11.
  typedef struct packed {
    logic [2:0]                  status;
    logic                        kind;
    logic [EVT_BYTES-1:0][7:0]   data;
  } evt_t;

endpackage

// File: sv/urfc_front.sv
// Front end: frame hunting, byte collection, timeout and classification.
`timescale 1ns / 1ps

module urfc_front #(
  parameter int VERSION_FRAME_MAX = 32,
  parameter int INFO_FRAME_MAX    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  urfc_pkg::in_t         in_item,
  input  logic                  cfg_we,
  input  logic [9:0]            cfg_data,
  output logic                  evt_valid,
  output urfc_pkg::evt_t        evt
);
  import urfc_pkg::*;

  localparam int LIM_MAX = (VERSION_FRAME_MAX > INFO_FRAME_MAX) ?
                           VERSION_FRAME_MAX : INFO_FRAME_MAX;
  localparam int CNT_W   = $clog2(LIM_MAX + 1);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HUNT = 3'b010,
    PH_RECV = 3'b100
  } phase_t;

  phase_t            phase;
  logic              active_kind;
  logic [CNT_W-1:0]  byte_count;
  logic [7:0]        length_byte;
  logic [7:0]        running_xor;
  logic [7:0]        hdr0;
  logic [7:0]        hdr1;
  logic [7:0]        field_bytes [FIELD_N];
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] timeout_ms;

  logic [TICK_W-1:0]      tick_next;
  logic [CNT_W-1:0]       count_next;
  logic [7:0]             xor_next;
  logic [LEN_W-1:0]       pkt_len;
  logic [LEN_W-1:0]       limit;
  logic                   is_byte;
  logic                   is_tick;
  logic                   fld_we;
  logic [FIELD_IDX_W-1:0] fld_idx;
  logic [CNT_W-1:0]       fld_off;
  logic [2:0]             frame_status;
  logic [7:0]             exp_cmd0;
  logic [7:0]             exp_cmd1;
  logic [7:0]             min_pay;

  assign is_byte    = in_fire && (in_item.func == FN_BYTE) && (phase != PH_IDLE);
  assign is_tick    = in_fire && (in_item.func == FN_TICK) && (phase != PH_IDLE);
  assign tick_next  = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign count_next = byte_count + 1'b1;
  assign xor_next   = running_xor ^ in_item.rx_byte;
  assign pkt_len    = LEN_W'(HDR_BYTES + 1) + LEN_W'(length_byte);
  assign limit      = active_kind ? LEN_W'(INFO_FRAME_MAX) : LEN_W'(VERSION_FRAME_MAX);
  assign fld_off    = byte_count - CNT_W'(HDR_BYTES);
  assign fld_idx    = fld_off[FIELD_IDX_W-1:0];
  assign fld_we     = is_byte && (phase == PH_RECV) &&
                      (LEN_W'(byte_count) >= LEN_W'(HDR_BYTES)) &&
                      (LEN_W'(byte_count) < LEN_W'(HDR_BYTES + FIELD_N));
  assign exp_cmd0   = active_kind ? INFO_CMD0 : VER_CMD0;
  assign exp_cmd1   = active_kind ? INFO_CMD1 : VER_CMD1;
  assign min_pay    = active_kind ? INFO_MIN_PAYLOAD : VER_MIN_PAYLOAD;

  // Order decides: check byte, then command pair, then payload length
  always_comb begin
    priority if (xor_next != 8'd0) begin
      frame_status = ST_BAD_CHECK;
    end else if (hdr0 != exp_cmd0 || hdr1 != exp_cmd1) begin
      frame_status = ST_WRONG_CMD;
    end else if (length_byte < min_pay) begin
      frame_status = ST_SHORT;
    end else begin
      frame_status = ST_OK;
    end
  end

  // Classify the item: at most one frame-end transfer toward the back
  always_comb begin
    evt_valid  = 1'b0;
    evt.status = ST_OK;
    evt.kind   = active_kind;
    for (int i = 0; i < EVT_INFO_TYPE; i++) begin
      evt.data[i] = field_bytes[i];
    end
    evt.data[EVT_INFO_TYPE] = field_bytes[FIELD_N-1];
    if (is_tick && (tick_next >= timeout_ms)) begin
      evt_valid  = 1'b1;
      evt.status = ST_TIMEOUT;
    end else if (is_byte && phase == PH_RECV &&
                 LEN_W'(count_next) >= LEN_W'(HDR_BYTES + 1)) begin
      if (pkt_len > limit) begin
        evt_valid  = 1'b1;
        evt.status = ST_TOO_LONG;
      end else if (LEN_W'(count_next) >= pkt_len) begin
        evt_valid  = 1'b1;
        evt.status = frame_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fld_we) begin
      field_bytes[fld_idx] <= in_item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      active_kind <= 1'b0;
      byte_count  <= '0;
      length_byte <= 8'd0;
      running_xor <= 8'd0;
      hdr0        <= 8'd0;
      hdr1        <= 8'd0;
      tick_count  <= '0;
      timeout_ms  <= TICK_W'(200);
    end else begin
      if (cfg_we) begin
        timeout_ms <= cfg_data;
      end
      if (in_fire && in_item.func == FN_START) begin
        // Restart: any running probe is dropped without a result
        phase       <= PH_HUNT;
        active_kind <= in_item.probe_kind;
        byte_count  <= '0;
        length_byte <= 8'd0;
        running_xor <= 8'd0;
        hdr0        <= 8'd0;
        hdr1        <= 8'd0;
        tick_count  <= '0;
      end else if (is_tick) begin
        tick_count <= tick_next;
        if (evt_valid) begin
          phase <= PH_IDLE;
        end
      end else if (is_byte) begin
        unique case (phase)
          PH_HUNT: begin
            if (in_item.rx_byte == START_BYTE) begin
              phase      <= PH_RECV;
              byte_count <= CNT_W'(1);
            end
          end
          PH_RECV: begin
            if (byte_count == CNT_W'(1)) begin
              length_byte <= in_item.rx_byte;
            end
            if (byte_count == CNT_W'(2)) begin
              hdr0 <= in_item.rx_byte;
            end
            if (byte_count == CNT_W'(3)) begin
              hdr1 <= in_item.rx_byte;
            end
            running_xor <= xor_next;
            byte_count  <= count_next;
            if (evt_valid) begin
              phase <= PH_IDLE;
            end
          end
          default: begin
            phase <= PH_IDLE;
          end
        endcase
      end
    end
  end

  a_evt_ends_probe: assert property (@(posedge clk) disable iff (rst)
    evt_valid |=> phase == PH_IDLE)
    else $error("probe still active after its result");

  a_recv_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RECV |-> byte_count != '0 && LEN_W'(byte_count) <= limit)
    else $error("byte count out of range while receiving");

endmodule

// File: sv/urfc_fifo.sv
// Short queue of classified frame ends between front and back.
`timescale 1ns / 1ps

module urfc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue fill count lost a transfer");

endmodule

// File: sv/urfc_back.sv
// Back end: decodes frame ends into result items behind an output register.
`timescale 1ns / 1ps

module urfc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  output logic           evt_ready,
  input  urfc_pkg::evt_t evt,
  output logic           out_valid,
  input  logic           out_ready,
  output urfc_pkg::out_t out_data
);
  import urfc_pkg::*;

  out_t       res;
  logic [7:0] dev_type;

  assign evt_ready = !out_valid || out_ready;
  assign dev_type  = evt.data[EVT_INFO_TYPE];

  // Data fields stay zero unless the result is ok for the matching kind
  always_comb begin
    res           = '0;
    res.status    = evt.status;
    res.kind_done = evt.kind;
    if (evt.status == ST_OK) begin
      if (evt.kind) begin
        if (dev_type > MAX_ROLE) begin
          res.status = ST_UNKNOWN;
        end else begin
          res.role          = dev_type[1:0];
          res.device_status = evt.data[0];
        end
      end else begin
        res.transport_rev = evt.data[0];
        res.product       = evt.data[1];
        res.chip_family   = (evt.data[1] <= MAX_FAMILY) ? evt.data[1][1:0] : FAMILY_UNKNOWN;
        res.major_rel     = evt.data[2];
        res.minor_rel     = evt.data[3];
        res.maint_rel     = evt.data[4];
        res.revision      = {evt.data[8], evt.data[7], evt.data[6], evt.data[5]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (evt_ready) begin
      out_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      out_data <= res;
    end
  end

  a_role_known: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OK && out_data.kind_done |->
      out_data.role != 2'd3)
    else $error("ok device info result with unknown role");

endmodule

// File: sv/mt_unpi_response_frame_checker.sv
// Response frame checker for a framed serial request/response probe.
//
// Input channel (in_valid/in_ready/in_data): one transfer per start command,
// received byte or millisecond tick. A start arms the checker for one response
// of the chosen kind; bytes before the 0xFE start byte are dropped.
// Output channel (out_valid/out_ready/out_data): exactly one result per ended
// probe (ok with decoded fields, timeout, too long, bad check byte, wrong
// command, short, unknown device type).
// cfg_we/cfg_data write the timeout in ticks (reset value 200).
// Throughput: one input transfer per cycle while in_ready is high. The front
// end updates its frame state in the cycle of the transfer; the result of the
// transfer that ends the probe passes through the queue and then into the
// output register. A two-entry queue sits between front and back; while the
// receiver stalls, input keeps flowing until that queue and the output register
// are both full, then in_ready drops. Reset clears all control state and goes
// idle.
`timescale 1ns / 1ps

module mt_unpi_response_frame_checker #(
  parameter int VERSION_FRAME_MAX = 32,
  parameter int INFO_FRAME_MAX    = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  urfc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output urfc_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [9:0]     cfg_data
);
  import urfc_pkg::*;

  localparam int Q_DEPTH = 2;

  logic in_fire;
  logic fe_valid;
  evt_t fe_evt;
  logic q_valid;
  logic q_ready;
  evt_t q_evt;

  assign in_fire = in_valid && in_ready;

  urfc_front #(
    .VERSION_FRAME_MAX(VERSION_FRAME_MAX),
    .INFO_FRAME_MAX   (INFO_FRAME_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_item  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .evt_valid(fe_valid),
    .evt      (fe_evt)
  );

  urfc_fifo #(
    .WIDTH($bits(evt_t)),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fe_valid),
    .push_ready(in_ready),
    .push_data (fe_evt),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_evt)
  );

  urfc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .evt_valid(q_valid),
    .evt_ready(q_ready),
    .evt      (q_evt),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
